@@ rtl/core/tcpop_pkg.sv @@
// Shared types, option codes and constants of the TCP option parser.
`default_nettype none

package tcpop_pkg;

    localparam int unsigned MAX_OPTION_BYTES = 40;
    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] MAX_AREA_LEN = POS_W'(MAX_OPTION_BYTES);

    localparam logic [7:0] KIND_EOL       = 8'd0;
    localparam logic [7:0] KIND_NOP       = 8'd1;
    localparam logic [7:0] KIND_MSS       = 8'd2;
    localparam logic [7:0] KIND_WSCALE    = 8'd3;
    localparam logic [7:0] KIND_SACK_PERM = 8'd4;
    localparam logic [7:0] KIND_TS        = 8'd8;

    localparam logic [7:0] MSS_DATA_BYTES    = 8'd2;
    localparam logic [7:0] WSCALE_DATA_BYTES = 8'd1;
    localparam logic [7:0] TS_DATA_BYTES     = 8'd8;
    localparam logic [7:0] TS_VALUE_TAIL     = 8'd4;
    localparam logic [7:0] MIN_OPT_LEN       = 8'd2;
    localparam logic [15:0] MSS_OVERHEAD     = 16'd12;

    localparam logic [1:0] CAUSE_EXHAUSTED = 2'd0;
    localparam logic [1:0] CAUSE_END       = 2'd1;
    localparam logic [1:0] CAUSE_OVERRUN   = 2'd2;
    localparam logic [1:0] CAUSE_BAD_LEN   = 2'd3;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_DATA,
        PH_SKIP,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [POS_W-1:0] byte_pos;
        phase_t           phase;
        logic [7:0]       kind;
        logic [7:0]       consume;
        logic [31:0]      shift;
        logic             mss_seen;
        logic [15:0]      mss_val;
        logic             ws_seen;
        logic [7:0]       ws_val;
        logic             sack;
        logic             ts_seen;
        logic [31:0]      ts_val;
        logic [31:0]      ts_time;
        logic [1:0]       stop_code;
    } state_t;

    typedef struct packed {
        logic        mss_seen;
        logic [15:0] mss_value;
        logic [15:0] eff_mss;
        logic        wscale_seen;
        logic [7:0]  wscale_value;
        logic        sack_permitted;
        logic        ts_seen;
        logic [31:0] ts_value;
        logic [31:0] ts_update_time;
        logic [1:0]  stop_cause;
    } result_t;

    function automatic state_t state_reset();
        state_t s;
        s           = '0;
        s.phase     = PH_KIND;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcpop_parse.sv @@
// Per-beat option walker: next parser state and the summary it would give.
`default_nettype none

module tcpop_parse (
    input  var tcpop_pkg::state_t  cur,
    input  wire logic [7:0]        opt_byte,
    input  wire logic [5:0]        area_len,
    input  wire logic [31:0]       now_ts,
    output tcpop_pkg::state_t      nxt,
    output tcpop_pkg::result_t     summary
);

    logic [5:0] len_eff;
    logic [9:0] reach;
    logic [9:0] limit;

    assign len_eff = (area_len > tcpop_pkg::MAX_AREA_LEN) ? tcpop_pkg::MAX_AREA_LEN : area_len;
    assign reach   = 10'(cur.byte_pos) + 10'd1 + 10'(opt_byte);
    assign limit   = 10'(len_eff) + 10'(tcpop_pkg::MIN_OPT_LEN);

    always_comb
    begin
        logic [31:0] shifted;
        logic [7:0]  left;
        nxt     = cur;
        shifted = cur.shift;
        left    = cur.consume - 8'd1;
        if (cur.phase != tcpop_pkg::PH_STOP && cur.byte_pos < len_eff)
        begin
            nxt.byte_pos = cur.byte_pos + 6'd1;
            unique case (cur.phase)
                tcpop_pkg::PH_KIND:
                begin
                    if (opt_byte == tcpop_pkg::KIND_EOL)
                    begin
                        nxt.stop_code = tcpop_pkg::CAUSE_END;
                        nxt.phase     = tcpop_pkg::PH_STOP;
                    end
                    else if (opt_byte != tcpop_pkg::KIND_NOP)
                    begin
                        nxt.kind  = opt_byte;
                        nxt.phase = tcpop_pkg::PH_LEN;
                    end
                end
                tcpop_pkg::PH_LEN:
                begin
                    if (reach > limit)
                    begin
                        nxt.stop_code = tcpop_pkg::CAUSE_OVERRUN;
                        nxt.phase     = tcpop_pkg::PH_STOP;
                    end
                    else if (cur.kind == tcpop_pkg::KIND_MSS)
                    begin
                        nxt.consume = tcpop_pkg::MSS_DATA_BYTES;
                        nxt.shift   = '0;
                        nxt.phase   = tcpop_pkg::PH_DATA;
                    end
                    else if (cur.kind == tcpop_pkg::KIND_WSCALE)
                    begin
                        nxt.consume = tcpop_pkg::WSCALE_DATA_BYTES;
                        nxt.shift   = '0;
                        nxt.phase   = tcpop_pkg::PH_DATA;
                    end
                    else if (cur.kind == tcpop_pkg::KIND_TS)
                    begin
                        nxt.consume = tcpop_pkg::TS_DATA_BYTES;
                        nxt.shift   = '0;
                        nxt.phase   = tcpop_pkg::PH_DATA;
                    end
                    else if (cur.kind == tcpop_pkg::KIND_SACK_PERM)
                    begin
                        nxt.sack  = 1'b1;
                        nxt.phase = tcpop_pkg::PH_KIND;
                    end
                    else if (opt_byte < tcpop_pkg::MIN_OPT_LEN)
                    begin
                        nxt.stop_code = tcpop_pkg::CAUSE_BAD_LEN;
                        nxt.phase     = tcpop_pkg::PH_STOP;
                    end
                    else if (opt_byte == tcpop_pkg::MIN_OPT_LEN)
                    begin
                        nxt.phase = tcpop_pkg::PH_KIND;
                    end
                    else
                    begin
                        nxt.consume = opt_byte - tcpop_pkg::MIN_OPT_LEN;
                        nxt.phase   = tcpop_pkg::PH_SKIP;
                    end
                end
                tcpop_pkg::PH_DATA:
                begin
                    if (cur.kind != tcpop_pkg::KIND_TS || cur.consume > tcpop_pkg::TS_VALUE_TAIL)
                    begin
                        shifted = {cur.shift[23:0], opt_byte};
                    end
                    nxt.shift   = shifted;
                    nxt.consume = left;
                    if (left == 8'd0)
                    begin
                        nxt.phase = tcpop_pkg::PH_KIND;
                        if (cur.kind == tcpop_pkg::KIND_MSS)
                        begin
                            nxt.mss_seen = 1'b1;
                            nxt.mss_val  = shifted[15:0];
                        end
                        else if (cur.kind == tcpop_pkg::KIND_WSCALE)
                        begin
                            nxt.ws_seen = 1'b1;
                            nxt.ws_val  = shifted[7:0];
                        end
                        else
                        begin
                            nxt.ts_seen = 1'b1;
                            nxt.ts_val  = shifted;
                            nxt.ts_time = now_ts;
                        end
                    end
                end
                tcpop_pkg::PH_SKIP:
                begin
                    nxt.consume = left;
                    if (left == 8'd0)
                    begin
                        nxt.phase = tcpop_pkg::PH_KIND;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

    always_comb
    begin
        summary.mss_seen       = nxt.mss_seen;
        summary.mss_value      = nxt.mss_seen ? nxt.mss_val : 16'd0;
        summary.eff_mss        = nxt.mss_seen ? (nxt.mss_val - tcpop_pkg::MSS_OVERHEAD) : 16'd0;
        summary.wscale_seen    = nxt.ws_seen;
        summary.wscale_value   = nxt.ws_seen ? nxt.ws_val : 8'd0;
        summary.sack_permitted = nxt.sack;
        summary.ts_seen        = nxt.ts_seen;
        summary.ts_value       = nxt.ts_seen ? nxt.ts_val : 32'd0;
        summary.ts_update_time = nxt.ts_seen ? nxt.ts_time : 32'd0;
        if (nxt.phase == tcpop_pkg::PH_STOP)
        begin
            summary.stop_cause = nxt.stop_code;
        end
        else if (nxt.phase != tcpop_pkg::PH_KIND)
        begin
            summary.stop_cause = tcpop_pkg::CAUSE_OVERRUN;
        end
        else
        begin
            summary.stop_cause = tcpop_pkg::CAUSE_EXHAUSTED;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tcp_option_parser_top.sv @@
// Top level of the TCP option parser: input register, parser state and result register.
//
// The block takes the option area of a TCP segment one byte per beat and gives one
// summary beat (MSS, window scale, SACK-permitted, timestamp and the stop cause) for
// the beat marked last_byte; all other beats give nothing. It sustains one byte per
// clock while no final byte is held back: each byte passes an input register and then
// the parser update logic, and the summary is written to the result register as the
// final byte leaves the input register. Bytes keep flowing while a summary waits; only
// a further final byte stalls until the pending summary is taken. After the summary
// the parser returns to its reset state for the next segment.
`default_nettype none

module tcp_option_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  opt_byte,
    input  wire logic [5:0]  area_len,
    input  wire logic        last_byte,
    input  wire logic [31:0] now_ts,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             mss_seen,
    output logic [15:0]      mss_value,
    output logic [15:0]      eff_mss,
    output logic             wscale_seen,
    output logic [7:0]       wscale_value,
    output logic             sack_permitted,
    output logic             ts_seen,
    output logic [31:0]      ts_value,
    output logic [31:0]      ts_update_time,
    output logic [1:0]       stop_cause
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic [5:0]  len_reg;
    logic        last_reg;
    logic [31:0] now_reg;

    tcpop_pkg::state_t  state_reg;
    tcpop_pkg::state_t  state_next;
    tcpop_pkg::result_t summary;
    tcpop_pkg::result_t result_reg;
    logic               out_valid_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= opt_byte;
            len_reg  <= area_len;
            last_reg <= last_byte;
            now_reg  <= now_ts;
        end
    end

    tcpop_parse u_parse (
        .cur      (state_reg),
        .opt_byte (byte_reg),
        .area_len (len_reg),
        .now_ts   (now_reg),
        .nxt      (state_next),
        .summary  (summary)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcpop_pkg::state_reset();
        end
        else if (advance)
        begin
            state_reg <= last_reg ? tcpop_pkg::state_reset() : state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            result_reg <= summary;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mss_seen       = result_reg.mss_seen;
    assign mss_value      = result_reg.mss_value;
    assign eff_mss        = result_reg.eff_mss;
    assign wscale_seen    = result_reg.wscale_seen;
    assign wscale_value   = result_reg.wscale_value;
    assign sack_permitted = result_reg.sack_permitted;
    assign ts_seen        = result_reg.ts_seen;
    assign ts_value       = result_reg.ts_value;
    assign ts_update_time = result_reg.ts_update_time;
    assign stop_cause     = result_reg.stop_cause;

endmodule

`default_nettype wire

@@ tb/sv/tcp_option_parser_top_test.sv @@
// Self-checking testbench of the TCP option parser, with an option summary scoreboard.
`timescale 1ns / 1ps

module tcp_option_parser_top_test;

    import tcpop_pkg::*;

    typedef logic [7:0] octet_q_t[$];

    class option_scoreboard;
        int unsigned fail_count;
        result_t     summary_q[$];
        logic [5:0]  pos;
        phase_t      phase;
        logic [7:0]  kind;
        logic [7:0]  remaining;
        logic [31:0] shift;
        logic        mss_seen;
        logic [15:0] mss_val;
        logic        ws_seen;
        logic [7:0]  ws_val;
        logic        sack;
        logic        ts_seen;
        logic [31:0] ts_val;
        logic [31:0] ts_time;
        logic [1:0]  stop_code;

        function new();
            fail_count = 0;
            clear();
        endfunction

        function void clear();
            pos       = '0;
            phase     = PH_KIND;
            kind      = '0;
            remaining = '0;
            shift     = '0;
            mss_seen  = 1'b0;
            mss_val   = '0;
            ws_seen   = 1'b0;
            ws_val    = '0;
            sack      = 1'b0;
            ts_seen   = 1'b0;
            ts_val    = '0;
            ts_time   = '0;
            stop_code = CAUSE_EXHAUSTED;
        endfunction

        function int pending();
            return summary_q.size();
        endfunction

        function void parse_byte(logic [7:0] b, logic [5:0] len, logic [31:0] now);
            case (phase)
                PH_KIND:
                begin
                    if (b == KIND_EOL)
                    begin
                        stop_code = CAUSE_END;
                        phase     = PH_STOP;
                    end
                    else if (b != KIND_NOP)
                    begin
                        kind  = b;
                        phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (int'(pos) + 1 + int'(b) > int'(len) + 2)
                    begin
                        stop_code = CAUSE_OVERRUN;
                        phase     = PH_STOP;
                    end
                    else if (kind == KIND_MSS || kind == KIND_WSCALE || kind == KIND_TS)
                    begin
                        remaining = (kind == KIND_MSS) ? MSS_DATA_BYTES :
                                    (kind == KIND_WSCALE) ? WSCALE_DATA_BYTES : TS_DATA_BYTES;
                        shift     = '0;
                        phase     = PH_DATA;
                    end
                    else if (kind == KIND_SACK_PERM)
                    begin
                        sack  = 1'b1;
                        phase = PH_KIND;
                    end
                    else if (b < MIN_OPT_LEN)
                    begin
                        stop_code = CAUSE_BAD_LEN;
                        phase     = PH_STOP;
                    end
                    else if (b == MIN_OPT_LEN)
                    begin
                        phase = PH_KIND;
                    end
                    else
                    begin
                        remaining = b - MIN_OPT_LEN;
                        phase     = PH_SKIP;
                    end
                end
                PH_DATA:
                begin
                    if (kind != KIND_TS || remaining > TS_VALUE_TAIL)
                        shift = {shift[23:0], b};
                    remaining = remaining - 8'd1;
                    if (remaining == '0)
                    begin
                        if (kind == KIND_MSS)
                        begin
                            mss_seen = 1'b1;
                            mss_val  = shift[15:0];
                        end
                        else if (kind == KIND_WSCALE)
                        begin
                            ws_seen = 1'b1;
                            ws_val  = shift[7:0];
                        end
                        else
                        begin
                            ts_seen = 1'b1;
                            ts_val  = shift;
                            ts_time = now;
                        end
                        phase = PH_KIND;
                    end
                end
                PH_SKIP:
                begin
                    remaining = remaining - 8'd1;
                    if (remaining == '0)
                        phase = PH_KIND;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic [5:0] area, logic last_flag,
                                logic [31:0] now);
            logic [5:0] len;
            result_t    r;
            len = (area > MAX_AREA_LEN) ? MAX_AREA_LEN : area;
            if (phase != PH_STOP && pos < len)
            begin
                parse_byte(b, len, now);
                pos = pos + 6'd1;
            end
            if (last_flag)
            begin
                r.mss_seen       = mss_seen;
                r.mss_value      = mss_val;
                r.eff_mss        = mss_seen ? mss_val - MSS_OVERHEAD : 16'd0;
                r.wscale_seen    = ws_seen;
                r.wscale_value   = ws_val;
                r.sack_permitted = sack;
                r.ts_seen        = ts_seen;
                r.ts_value       = ts_val;
                r.ts_update_time = ts_time;
                if (phase == PH_STOP)
                    r.stop_cause = stop_code;
                else if (phase != PH_KIND)
                    r.stop_cause = CAUSE_OVERRUN;
                else
                    r.stop_cause = CAUSE_EXHAUSTED;
                summary_q.push_back(r);
                clear();
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            fail_count++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, wanted %0h", name, got, want));
        endtask

        task check_summary(result_t got);
            result_t want;
            if (summary_q.size() == 0)
            begin
                report("summary beat with no summary outstanding");
                return;
            end
            want = summary_q.pop_front();
            compare_field("mss_seen", 32'(got.mss_seen), 32'(want.mss_seen));
            compare_field("mss_value", 32'(got.mss_value), 32'(want.mss_value));
            compare_field("eff_mss", 32'(got.eff_mss), 32'(want.eff_mss));
            compare_field("wscale_seen", 32'(got.wscale_seen), 32'(want.wscale_seen));
            compare_field("wscale_value", 32'(got.wscale_value), 32'(want.wscale_value));
            compare_field("sack_permitted", 32'(got.sack_permitted),
                          32'(want.sack_permitted));
            compare_field("ts_seen", 32'(got.ts_seen), 32'(want.ts_seen));
            compare_field("ts_value", got.ts_value, want.ts_value);
            compare_field("ts_update_time", got.ts_update_time, want.ts_update_time);
            compare_field("stop_cause", 32'(got.stop_cause), 32'(want.stop_cause));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  opt_byte = '0;
    logic [5:0]  area_len = '0;
    logic        last_byte = 1'b0;
    logic [31:0] now_ts = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        mss_seen;
    logic [15:0] mss_value;
    logic [15:0] eff_mss;
    logic        wscale_seen;
    logic [7:0]  wscale_value;
    logic        sack_permitted;
    logic        ts_seen;
    logic [31:0] ts_value;
    logic [31:0] ts_update_time;
    logic [1:0]  stop_cause;

    option_scoreboard sb = new();
    int unsigned      send_idle_pct = 20;
    int unsigned      recv_idle_pct = 49;
    int unsigned      byte_count = 0;

    tcp_option_parser_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opt_byte       (opt_byte),
        .area_len       (area_len),
        .last_byte      (last_byte),
        .now_ts         (now_ts),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mss_seen       (mss_seen),
        .mss_value      (mss_value),
        .eff_mss        (eff_mss),
        .wscale_seen    (wscale_seen),
        .wscale_value   (wscale_value),
        .sack_permitted (sack_permitted),
        .ts_seen        (ts_seen),
        .ts_value       (ts_value),
        .ts_update_time (ts_update_time),
        .stop_cause     (stop_cause)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_t got;
        got = {mss_seen, mss_value, eff_mss, wscale_seen, wscale_value, sack_permitted,
               ts_seen, ts_value, ts_update_time, stop_cause};
        if (rst_n && out_valid && out_ready)
            sb.check_summary(got);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic [5:0] area,
                             input logic last_flag);
        logic [31:0] now;
        now = $urandom();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        opt_byte  <= b;
        area_len  <= area;
        last_byte <= last_flag;
        now_ts    <= now;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, area, last_flag, now);
        byte_count++;
    endtask

    task automatic send_segment(input octet_q_t seg, input logic [5:0] area,
                                input bit vary_area);
        foreach (seg[i])
            send_byte(seg[i], vary_area ? 6'($urandom_range(63)) : area, i == seg.size() - 1);
    endtask

    function automatic octet_q_t build_options(int target);
        octet_q_t s;
        int       room;
        int       olen;
        logic [7:0] k;
        while (s.size() < target)
        begin
            room = target - s.size();
            case ($urandom_range(9))
                1:
                    if (room >= 4)
                    begin
                        s.push_back(KIND_MSS);
                        s.push_back(8'd4);
                        s.push_back(8'($urandom()));
                        s.push_back(8'($urandom()));
                    end
                2:
                    if (room >= 3)
                    begin
                        s.push_back(KIND_WSCALE);
                        s.push_back(8'd3);
                        s.push_back(8'($urandom()));
                    end
                3:
                    if (room >= 2)
                    begin
                        s.push_back(KIND_SACK_PERM);
                        s.push_back(MIN_OPT_LEN);
                    end
                4, 5:
                    if (room >= 10)
                    begin
                        s.push_back(KIND_TS);
                        s.push_back(8'd10);
                        repeat (8)
                            s.push_back(8'($urandom()));
                    end
                6:
                    if (room >= 2)
                    begin
                        k = 8'($urandom_range(5, 255));
                        if (k == KIND_TS)
                            k = 8'd9;
                        olen = $urandom_range(2, (room < 12) ? room : 12);
                        s.push_back(k);
                        s.push_back(8'(olen));
                        repeat (olen - 2)
                            s.push_back(8'($urandom()));
                    end
                7:
                begin
                    s.push_back(KIND_EOL);
                    while (s.size() < target)
                        s.push_back(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom()));
                end
                default:
                    s.push_back(KIND_NOP);
            endcase
            if (target - s.size() == room)
                s.push_back(KIND_NOP);
        end
        return s;
    endfunction

    task automatic random_segment();
        octet_q_t   seg;
        int         target;
        logic [5:0] area;
        if ($urandom_range(99) < 75)
        begin
            target = $urandom_range(40);
            seg = build_options(target);
            area = 6'(target);
            if ($urandom_range(99) < 15 && seg.size() > 0)
                seg[$urandom_range(seg.size() - 1)] = 8'($urandom());
            if ($urandom_range(99) < 10)
            begin
                repeat ($urandom_range(1, 4))
                    seg.push_back(8'($urandom()));
            end
            else if ($urandom_range(99) < 12 && seg.size() > 1)
            begin
                seg = seg[0:$urandom_range(seg.size() - 2)];
            end
            if ($urandom_range(99) < 5)
                area = 6'($urandom_range(target, 63));
            if (seg.size() == 0)
                seg.push_back(8'($urandom()));
            send_segment(seg, area, 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 48))
                seg.push_back(($urandom_range(2) == 0) ? 8'($urandom_range(10))
                                                       : 8'($urandom()));
            send_segment(seg, 6'($urandom_range(63)), 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_for_summaries();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        octet_q_t seg;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty area, a byte that lies beyond it.
        seg = '{8'hFF};
        send_segment(seg, 6'd0, 1'b0);
        // MSS with a zero length byte and a value that wraps the effective MSS.
        seg = '{KIND_MSS, 8'd0, 8'h00, 8'h05};
        send_segment(seg, 6'd4, 1'b0);
        // Timestamp with all value bits high.
        seg = '{KIND_TS, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
        send_segment(seg, 6'd10, 1'b0);
        // Oversized area, window scale, SACK-permitted, end of list and a byte after it.
        seg = '{KIND_WSCALE, 8'd3, 8'hFF, KIND_SACK_PERM, MIN_OPT_LEN, KIND_EOL, 8'hA5};
        send_segment(seg, 6'd63, 1'b0);
        // Unknown kind whose length is too short.
        seg = '{8'd9, 8'd1};
        send_segment(seg, 6'd20, 1'b0);
        // Option that reaches past the area.
        seg = '{KIND_MSS, 8'd9};
        send_segment(seg, 6'd2, 1'b0);
        wait_for_summaries();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 49 : 0;
            recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 20 : 0;
            while (byte_count < 370 + ph * 340)
                random_segment();
            wait_for_summaries();
        end

        wait_for_summaries();
        repeat (20)
            @(posedge clk);
        if (sb.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tcpop_pkg.sv
rtl/core/tcpop_parse.sv
rtl/core/tcp_option_parser_top.sv
tb/sv/tcp_option_parser_top_test.sv
